// ----- rtl/mvm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants of the fixed-point matrix-vector multiplier.
// ----------------------------------------------------------------------------
package mvm_pkg;

  localparam int ROW_W     = 6;
  localparam int COL_W     = 8;
  localparam int VAL_W     = 16;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int DOT_W     = 32;
  localparam int IDX_W     = 6;
  localparam int LEN_IN_W  = 9;
  localparam int LEN_OUT_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 9;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Q9.23 products, summed and shifted to Q16.16
  localparam int ACC_SHIFT = 7;

  localparam logic [LEN_IN_W-1:0]  INPUT_LENGTH_RST  = 9'd256;
  localparam logic [LEN_OUT_W-1:0] OUTPUT_LENGTH_RST = 7'd64;

  localparam logic [DOT_W-1:0] DOT_MAX = 32'h7FFF_FFFF;
  localparam logic [DOT_W-1:0] DOT_MIN = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_LENGTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTH = 1'd1;

  localparam logic MODE_WEIGHT     = 1'b0;
  localparam logic MODE_ACTIVATION = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_EMIT
  } mvm_state_t;

  // sequencer to datapath
  typedef struct packed {
    logic rd_en;    // read one act/weight pair this cycle
    logic acc_clr;  // clear the accumulator
  } mvm_ctrl_t;

endpackage : mvm_pkg
`default_nettype wire

// ----- rtl/matrix_vector_multiply.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Fixed-point GEMV: weight and activation words fill two memories; the last
// activation element runs one shared MAC over the configured rows and emits
// Q16.16 dots. Weight and non-final activation words: one per cycle when idle.
// A final activation word with a nonzero output length holds the input until
// all rows are done: per row, one MAC per cycle, then pipe drain and hand-off.
// A stalled result word stretches the next row's hand-off.
// Reset: sync, active high; lengths return to 256 / 64, memories not cleared.
// ----------------------------------------------------------------------------
module matrix_vector_multiply #(
  parameter int MAX_IN    = 256,
  parameter int MAX_OUT   = 64,
  parameter int ACC_WIDTH = 48
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // row_index[5:0], col_index[13:6], value[29:14], zero pad
  input  wire  [mvm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  wire                                s_axis_tlast,  // last_element
  input  wire                                s_axis_tuser,  // mode
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // dot_value[31:0], out_index[37:32], zero pad
  output logic [mvm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,  // last_result
  input  wire                                cfg_we,
  input  wire  [mvm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [mvm_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import mvm_pkg::*;

  localparam int AW  = $clog2(MAX_IN);
  localparam int WAW = $clog2(MAX_OUT * MAX_IN);

  logic [LEN_IN_W-1:0]  input_length;
  logic [LEN_OUT_W-1:0] output_length;

  logic [ROW_W-1:0] row_index;
  logic [COL_W-1:0] col_index;
  logic [VAL_W-1:0] value;
  logic             accept;
  logic             w_we;
  logic             a_we;
  logic             start;
  logic [WAW-1:0]   w_waddr;
  logic [AW-1:0]    a_waddr;

  mvm_ctrl_t        ctrl;
  logic [WAW-1:0]   w_raddr;
  logic [AW-1:0]    a_raddr;
  logic [VAL_W-1:0] w_rdata;
  logic [VAL_W-1:0] a_rdata;
  logic             busy;
  logic [DOT_W-1:0] dot;
  logic             out_free;
  logic             emit;
  logic             emit_last;
  logic [IDX_W-1:0] emit_index;
  logic             ready;

  logic             out_valid;
  logic [DOT_W-1:0] dot_value;
  logic [IDX_W-1:0] out_index;
  logic             last_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_length  <= INPUT_LENGTH_RST;
      output_length <= OUTPUT_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INPUT_LENGTH:  input_length  <= cfg_data[LEN_IN_W-1:0];
        REG_OUTPUT_LENGTH: output_length <= cfg_data[LEN_OUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign row_index = s_axis_tdata[ROW_W-1:0];
  assign col_index = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
  assign value     = s_axis_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];

  assign s_axis_tready = ready;
  assign accept        = s_axis_tvalid && ready;

  // out-of-range addresses are dropped
  assign w_we  = accept && (s_axis_tuser == MODE_WEIGHT) &&
                 (32'(row_index) < MAX_OUT) && (32'(col_index) < MAX_IN);
  assign a_we  = accept && (s_axis_tuser == MODE_ACTIVATION) &&
                 (32'(col_index) < MAX_IN);
  assign start = accept && (s_axis_tuser == MODE_ACTIVATION) && s_axis_tlast;

  assign w_waddr = WAW'(32'(row_index) * MAX_IN + 32'(col_index));
  assign a_waddr = AW'(col_index);

  mvm_store #(
    .MAX_IN  (MAX_IN),
    .MAX_OUT (MAX_OUT),
    .AW      (AW),
    .WAW     (WAW)
  ) u_store (
    .clk     (clk),
    .w_we    (w_we),
    .w_waddr (w_waddr),
    .a_we    (a_we),
    .a_waddr (a_waddr),
    .wdata   (value),
    .ctrl    (ctrl),
    .w_raddr (w_raddr),
    .a_raddr (a_raddr),
    .w_rdata (w_rdata),
    .a_rdata (a_rdata)
  );

  mvm_mac #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .w_rdata (w_rdata),
    .a_rdata (a_rdata),
    .busy    (busy),
    .dot     (dot)
  );

  mvm_seq #(
    .MAX_IN  (MAX_IN),
    .MAX_OUT (MAX_OUT),
    .AW      (AW),
    .WAW     (WAW)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .input_length  (input_length),
    .output_length (output_length),
    .busy          (busy),
    .out_free      (out_free),
    .ready         (ready),
    .ctrl          (ctrl),
    .w_raddr       (w_raddr),
    .a_raddr       (a_raddr),
    .emit          (emit),
    .emit_last     (emit_last),
    .emit_index    (emit_index)
  );

  // output register: next row computes while this word waits
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dot_value   <= dot;
      out_index   <= emit_index;
      last_result <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - DOT_W - IDX_W){1'b0}}, out_index, dot_value};
  assign m_axis_tlast  = last_result;

endmodule : matrix_vector_multiply
`default_nettype wire

// ----- rtl/mvm_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mvm_store
// Weight store and activation buffer, one write and one registered read each.
// ----------------------------------------------------------------------------
module mvm_store #(
  parameter int MAX_IN  = 256,
  parameter int MAX_OUT = 64,
  parameter int AW      = $clog2(MAX_IN),
  parameter int WAW     = $clog2(MAX_OUT * MAX_IN)
) (
  input  wire                         clk,
  input  wire                         w_we,
  input  wire  [WAW-1:0]              w_waddr,
  input  wire                         a_we,
  input  wire  [AW-1:0]               a_waddr,
  input  wire  [mvm_pkg::VAL_W-1:0]   wdata,
  input  wire  mvm_pkg::mvm_ctrl_t    ctrl,
  input  wire  [WAW-1:0]              w_raddr,
  input  wire  [AW-1:0]               a_raddr,
  output logic [mvm_pkg::VAL_W-1:0]   w_rdata,
  output logic [mvm_pkg::VAL_W-1:0]   a_rdata
);
  import mvm_pkg::*;

  localparam int W_DEPTH = MAX_OUT * MAX_IN;

  logic [VAL_W-1:0] weight_mem [W_DEPTH];
  logic [VAL_W-1:0] act_mem    [MAX_IN];

  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[w_waddr] <= wdata;
    end
    if (ctrl.rd_en) begin
      w_rdata <= weight_mem[w_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      act_mem[a_waddr] <= wdata;
    end
    if (ctrl.rd_en) begin
      a_rdata <= act_mem[a_raddr];
    end
  end

endmodule : mvm_store
`default_nettype wire

// ----- rtl/mvm_mac.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mvm_mac
// Shared multiply-accumulate unit with Q16.16 shift and 32-bit saturation.
// ----------------------------------------------------------------------------
module mvm_mac #(
  parameter int ACC_WIDTH = 48
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire  mvm_pkg::mvm_ctrl_t    ctrl,
  input  wire  [mvm_pkg::VAL_W-1:0]   w_rdata,
  input  wire  [mvm_pkg::VAL_W-1:0]   a_rdata,
  output logic                        busy,
  output logic [mvm_pkg::DOT_W-1:0]   dot
);
  import mvm_pkg::*;

  localparam int SH_W = ACC_WIDTH - ACC_SHIFT;

  logic                         rd_v;
  logic                         mul_v;
  logic signed [PROD_W-1:0]     prod;
  logic [ACC_WIDTH-1:0]         acc;
  logic [SH_W-1:0]              sh;
  logic                         fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v  <= ctrl.rd_en;
      mul_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v) begin
      prod <= $signed(a_rdata) * $signed(w_rdata);
    end
  end

  // wraps modulo 2^ACC_WIDTH
  always_ff @(posedge clk) begin
    if (rst || ctrl.acc_clr) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + ACC_WIDTH'(prod);
    end
  end

  assign busy = rd_v | mul_v;

  // arithmetic shift = drop the low bits; fits when bit 31 and the bits above it are a sign run
  assign sh   = acc[ACC_WIDTH-1:ACC_SHIFT];
  assign fits = (sh[SH_W-1:DOT_W-1] == '0) || (sh[SH_W-1:DOT_W-1] == '1);

  always_comb begin
    if (fits) begin
      dot = sh[DOT_W-1:0];
    end else if (sh[SH_W-1]) begin
      dot = DOT_MIN;
    end else begin
      dot = DOT_MAX;
    end
  end

endmodule : mvm_mac
`default_nettype wire

// ----- rtl/mvm_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mvm_seq
// Sequencer: walks rows and columns, drains the MAC pipe, hands off results.
// ----------------------------------------------------------------------------
module mvm_seq #(
  parameter int MAX_IN  = 256,
  parameter int MAX_OUT = 64,
  parameter int AW      = $clog2(MAX_IN),
  parameter int WAW     = $clog2(MAX_OUT * MAX_IN)
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  input  wire  [mvm_pkg::LEN_IN_W-1:0]   input_length,
  input  wire  [mvm_pkg::LEN_OUT_W-1:0]  output_length,
  input  wire                            busy,
  input  wire                            out_free,
  output logic                           ready,
  output mvm_pkg::mvm_ctrl_t             ctrl,
  output logic [WAW-1:0]                 w_raddr,
  output logic [AW-1:0]                  a_raddr,
  output logic                           emit,
  output logic                           emit_last,
  output logic [mvm_pkg::IDX_W-1:0]      emit_index
);
  import mvm_pkg::*;

  localparam int NIW = $clog2(MAX_IN + 1);
  localparam int NOW = $clog2(MAX_OUT + 1);

  mvm_state_t       state, state_next;
  logic [NIW-1:0]   i_cnt, i_cnt_next;
  logic [NOW-1:0]   o_cnt, o_cnt_next;
  logic [WAW-1:0]   w_base, w_base_next;
  logic [NIW-1:0]   n_in;
  logic [NOW-1:0]   n_out;
  logic             row_done;
  logic             last_row;

  assign n_in  = (32'(input_length) > MAX_IN) ? NIW'(MAX_IN) : NIW'(input_length);
  assign n_out = (32'(output_length) > MAX_OUT) ? NOW'(MAX_OUT) : NOW'(output_length);

  assign row_done = (i_cnt == n_in);
  assign last_row = (o_cnt == n_out - NOW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      i_cnt  <= '0;
      o_cnt  <= '0;
      w_base <= '0;
    end else begin
      state  <= state_next;
      i_cnt  <= i_cnt_next;
      o_cnt  <= o_cnt_next;
      w_base <= w_base_next;
    end
  end

  always_comb begin
    state_next  = state;
    i_cnt_next  = i_cnt;
    o_cnt_next  = o_cnt;
    w_base_next = w_base;
    case (state)
      S_IDLE: begin
        if (start && (n_out != '0)) begin
          state_next  = S_RUN;
          i_cnt_next  = '0;
          o_cnt_next  = '0;
          w_base_next = '0;
        end
      end
      S_RUN: begin
        if (row_done) begin
          state_next = S_DRAIN;
        end else begin
          i_cnt_next = i_cnt + NIW'(1);
        end
      end
      S_DRAIN: begin
        if (!busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (last_row) begin
            state_next = S_IDLE;
          end else begin
            state_next  = S_RUN;
            i_cnt_next  = '0;
            o_cnt_next  = o_cnt + NOW'(1);
            w_base_next = w_base + WAW'(MAX_IN);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ready        = (state == S_IDLE);
    ctrl.rd_en   = (state == S_RUN) && !row_done;
    emit         = (state == S_EMIT) && out_free;
    ctrl.acc_clr = emit;
    emit_last    = last_row;
    emit_index   = IDX_W'(o_cnt);
    a_raddr      = AW'(i_cnt);
    w_raddr      = w_base + WAW'(i_cnt);
  end

endmodule : mvm_seq
`default_nettype wire

// ----- dv/gemv_dot_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gemv_dot_checker
// Watches the weight/activation stream, the config port and the dot stream.
// Keeps its own copy of the weight store, the activation vector and the
// lengths, predicts the dot products of every finished vector and compares
// each result word against the oldest pending prediction.
// ----------------------------------------------------------------------------
module gemv_dot_checker
  import mvm_pkg::*;
#(
  parameter int MAX_IN    = 256,
  parameter int MAX_OUT   = 64,
  parameter int ACC_WIDTH = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // row_index, col_index, value
  input  logic                   s_axis_tlast,   // last_element
  input  logic                   s_axis_tuser,   // mode
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // dot_value, out_index
  input  logic                   m_axis_tlast,   // last_result
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_data,
  output int                     mismatches,
  output int                     dots_pending
);

  typedef struct packed {
    logic [DOT_W-1:0] dot;
    logic [IDX_W-1:0] idx;
    logic             last;
  } dot_word_t;

  logic [VAL_W-1:0]     weights [0:MAX_OUT-1][0:MAX_IN-1];
  logic [VAL_W-1:0]     acts    [0:MAX_IN-1];
  logic [LEN_IN_W-1:0]  in_len_reg;
  logic [LEN_OUT_W-1:0] out_len_reg;
  dot_word_t            expected_dots [$];

  // exact sum, wrapped to the accumulator width, floor shift, saturate
  function automatic logic [DOT_W-1:0] predict_dot(input int row, input int n_in);
    longint               sum;
    logic [ACC_WIDTH-1:0] acc;
    longint               q;
    sum = 0;
    for (int i = 0; i < n_in; i++)
      sum += longint'($signed(acts[i])) * longint'($signed(weights[row][i]));
    acc = sum[ACC_WIDTH-1:0];
    q = longint'($signed(acc)) >>> ACC_SHIFT;
    if (q > 64'sd2147483647) return DOT_MAX;
    if (q < -64'sd2147483648) return DOT_MIN;
    return q[DOT_W-1:0];
  endfunction

  task automatic report(input string field, input longint want_v, input longint got_v);
    if (mismatches < 10)
      $display("%0t: dot mismatch on %s: expected %0d (0x%0h), got %0d (0x%0h)",
               $realtime, field, want_v, want_v, got_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    dot_word_t        got;
    dot_word_t        want;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] val;
    int               n_in;
    int               n_out;
    if (rst) begin
      in_len_reg  = INPUT_LENGTH_RST;
      out_len_reg = OUTPUT_LENGTH_RST;
      expected_dots.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_INPUT_LENGTH)
          in_len_reg = cfg_data[LEN_IN_W-1:0];
        else if (cfg_index == REG_OUTPUT_LENGTH)
          out_len_reg = cfg_data[LEN_OUT_W-1:0];
      end

      // results belong to earlier vectors, so retire them first
      if (m_axis_tvalid && m_axis_tready) begin
        got.dot  = m_axis_tdata[DOT_W-1:0];
        got.idx  = m_axis_tdata[DOT_W+IDX_W-1:DOT_W];
        got.last = m_axis_tlast;
        if (expected_dots.size() == 0) begin
          report("unexpected word (dot_value)", 0, $signed(got.dot));
        end else begin
          want = expected_dots.pop_front();
          if (got.dot !== want.dot)
            report("dot_value", $signed(want.dot), $signed(got.dot));
          if (got.idx !== want.idx)
            report("out_index", want.idx, got.idx);
          if (got.last !== want.last)
            report("last_result", want.last, got.last);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        row = s_axis_tdata[ROW_W-1:0];
        col = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
        val = s_axis_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];
        if (s_axis_tuser == MODE_WEIGHT) begin
          if (row < MAX_OUT && col < MAX_IN)
            weights[row][col] = val;
        end else begin
          if (col < MAX_IN)
            acts[col] = val;
          if (s_axis_tlast) begin
            n_in  = (in_len_reg > MAX_IN) ? MAX_IN : in_len_reg;
            n_out = (out_len_reg > MAX_OUT) ? MAX_OUT : out_len_reg;
            for (int o = 0; o < n_out; o++)
              expected_dots.push_back('{dot: predict_dot(o, n_in),
                                        idx: o[IDX_W-1:0],
                                        last: (o == n_out - 1)});
          end
        end
      end
    end
    dots_pending = expected_dots.size();
  end

endmodule

// ----- dv/tb_matrix_vector_multiply.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_vector_multiply
// Stimulus for the fixed-point GEMV block: directed weight/activation words
// covering value extremes, ignored flags and zero lengths, a saturating full
// length vector, then random phases of lengths and well-formed or noisy
// words with random idling on both streams. A side checker predicts the dots.
// ----------------------------------------------------------------------------
module tb_matrix_vector_multiply;
  import mvm_pkg::*;

  localparam int MAX_IN       = 256;
  localparam int MAX_OUT      = 64;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_WORDS = 320;
  localparam int QUIET_WORDS  = 60;
  localparam int DRAIN_CYCLES = MAX_IN + 16;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DAT_W-1:0]   cfg_data = '0;

  int mismatches;
  int dots_pending;
  int cycle_count = 0;
  int out_stall = 0;
  int random_count = 0;
  bit quiet = 1'b0;
  int cur_in;
  int cur_out;

  // tracks which entries were written, so no unwritten entry is ever read
  bit w_written [0:MAX_OUT-1][0:MAX_IN-1];
  bit a_written [0:MAX_IN-1];

  matrix_vector_multiply #(
    .MAX_IN (MAX_IN),
    .MAX_OUT(MAX_OUT)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  gemv_dot_checker #(
    .MAX_IN (MAX_IN),
    .MAX_OUT(MAX_OUT)
  ) dot_check (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .dots_pending (dots_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_stall     <= out_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall     <= $urandom_range(1, 17) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic mode, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val,
                           input logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {2'b00, val, col, row};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (mode == MODE_WEIGHT)
      w_written[row][col] = 1'b1;
    else
      a_written[col] = 1'b1;
  endtask

  task automatic set_lengths(input logic [CFG_DAT_W-1:0] in_data,
                             input logic [CFG_DAT_W-1:0] out_cfg);
    cfg_we    <= 1'b1;
    cfg_index <= REG_INPUT_LENGTH;
    cfg_data  <= in_data;
    @(posedge clk);
    cfg_index <= REG_OUTPUT_LENGTH;
    cfg_data  <= out_cfg;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_in  = (in_data > MAX_IN) ? MAX_IN : in_data;
    cur_out = (out_cfg[LEN_OUT_W-1:0] > MAX_OUT) ? MAX_OUT : out_cfg[LEN_OUT_W-1:0];
  endtask

  // hold off until every dot is out, then let a possibly silent vector settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (dots_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write every entry the next vector will read that is still unwritten
  task automatic fill_for_vector();
    for (int o = 0; o < cur_out; o++)
      for (int i = 0; i < cur_in; i++)
        if (!w_written[o][i])
          send_word(MODE_WEIGHT, o, i, rand_value(), $urandom_range(0, 1));
    for (int i = 0; i < cur_in; i++)
      if (!a_written[i])
        send_word(MODE_ACTIVATION, $urandom_range(0, 63), i, rand_value(), 1'b0);
  endtask

  task automatic finish_vector();
    fill_for_vector();
    send_word(MODE_ACTIVATION, $urandom, $urandom, rand_value(), 1'b1);
  endtask

  task automatic random_word();
    logic             mode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    if ($urandom_range(0, 9) < 7) begin
      mode = $urandom_range(0, 1);
      row  = (cur_out > 0) ? $urandom_range(0, cur_out - 1) : $urandom;
      col  = (cur_in > 0) ? $urandom_range(0, cur_in - 1) : $urandom;
      last = mode && ($urandom_range(0, 7) == 0);
    end else begin
      mode = $urandom;
      row  = $urandom;
      col  = $urandom;
      last = $urandom;
    end
    if (mode == MODE_ACTIVATION && last)
      fill_for_vector();
    send_word(mode, row, col, rand_value(), last);
  endtask

  task automatic random_phase();
    int               in_len;
    int               out_len;
    logic [CFG_DAT_W-1:0] out_cfg;
    case ($urandom_range(0, 9))
      0: begin
        in_len  = $urandom_range(MAX_IN, 511);
        out_len = $urandom_range(1, 2);
      end
      1: begin
        in_len  = $urandom_range(1, 4);
        out_len = $urandom_range(MAX_OUT, 127);
      end
      2: begin
        in_len  = 0;
        out_len = $urandom_range(0, 8);
      end
      3: begin
        in_len  = $urandom_range(1, 16);
        out_len = 0;
      end
      default: begin
        in_len  = $urandom_range(1, 16);
        out_len = $urandom_range(1, 8);
      end
    endcase
    // upper data bits are outside the output length register
    out_cfg = {2'($urandom), 7'(out_len)};
    set_lengths(9'(in_len), out_cfg);
    repeat ($urandom_range(8, 40)) begin
      random_word();
      random_count++;
      if (random_count > RANDOM_WORDS - QUIET_WORDS)
        quiet = 1'b1;
    end
    finish_vector();
    wait_idle();
  endtask

  initial begin
    for (int o = 0; o < MAX_OUT; o++)
      for (int i = 0; i < MAX_IN; i++)
        w_written[o][i] = 1'b0;
    for (int i = 0; i < MAX_IN; i++)
      a_written[i] = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // value extremes, last flag on a weight word, far corner of the store
    set_lengths(9'd3, 9'd3);
    send_word(MODE_WEIGHT, 0, 0, 16'h7FFF, 1'b0);
    send_word(MODE_WEIGHT, 0, 1, 16'h8000, 1'b0);
    send_word(MODE_WEIGHT, 0, 2, 16'h0001, 1'b0);
    send_word(MODE_WEIGHT, 1, 0, 16'h8000, 1'b0);
    send_word(MODE_WEIGHT, 1, 1, 16'h8000, 1'b0);
    send_word(MODE_WEIGHT, 1, 2, 16'hFFFF, 1'b0);
    send_word(MODE_WEIGHT, 2, 0, 16'h0000, 1'b0);
    send_word(MODE_WEIGHT, 2, 1, 16'h7FFF, 1'b0);
    send_word(MODE_WEIGHT, 2, 2, 16'h8000, 1'b1);
    send_word(MODE_WEIGHT, 63, 255, 16'h5A5A, 1'b0);
    send_word(MODE_ACTIVATION, 0, 0, 16'h7FFF, 1'b0);
    send_word(MODE_ACTIVATION, 63, 1, 16'h8000, 1'b0);
    send_word(MODE_ACTIVATION, 0, 2, 16'hFFFF, 1'b1);
    // last flag away from the final position
    send_word(MODE_ACTIVATION, 0, 255, 16'h1234, 1'b0);
    send_word(MODE_ACTIVATION, 21, 1, 16'h0001, 1'b1);
    wait_idle();
    // no rows: vector ends silently
    set_lengths(9'd3, 9'd0);
    send_word(MODE_ACTIVATION, 0, 0, 16'h8000, 1'b1);
    wait_idle();
    // empty sum: every dot is zero
    set_lengths(9'd0, 9'd2);
    send_word(MODE_ACTIVATION, 42, 2, 16'h7FFF, 1'b1);
    wait_idle();

    // full length with most-negative operands drives the dot into saturation
    set_lengths(9'h1FF, 9'd2);
    for (int o = 0; o < 2; o++)
      for (int i = 0; i < MAX_IN; i++)
        send_word(MODE_WEIGHT, o, i, 16'h8000, 1'b0);
    for (int i = 0; i < MAX_IN - 1; i++)
      send_word(MODE_ACTIVATION, 0, i, 16'h8000, 1'b0);
    send_word(MODE_ACTIVATION, 0, MAX_IN - 1, 16'h8000, 1'b1);
    wait_idle();

    // every row, output length beyond the maximum
    set_lengths(9'd1, 9'h17F);
    finish_vector();
    wait_idle();

    while (random_count < RANDOM_WORDS)
      random_phase();

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (dots_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && dots_pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
